// ===== src/lir_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lir_pkg
// Shared types and constants for the linear interpolation resampler.
// ============================================================================
package lir_pkg;

    // Pending destination frames, each waiting for a confirmed successor
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Maximum destination frames released for one source frame
    localparam int MAX_RESULTS = 32;
    localparam int ECNT_W      = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,     // wait for a source frame
        ST_DRAIN,    // release queued frames that are far enough behind
        ST_LOOP,     // decide whether another destination frame falls here
        ST_MUL_L,    // multiply left delta by fraction
        ST_MUL_R,    // finish left, multiply right delta by fraction
        ST_PUSH,     // finish right, enqueue the new destination frame
        ST_UPDATE,   // shift current frame into previous
        ST_FQ,       // end of run: release valid queued frames
        ST_FHOLD,    // end of run: repeat the last frame
        ST_FLUSH     // hand the staged frame to the output
    } lir_state_t;

endpackage

// ===== src/lir_stream_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lir_in_if / lir_out_if
// Valid/ready channels for source frames and destination frames.
// ============================================================================
interface lir_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          final_frame;

    modport source (output valid, sample_left, sample_right, final_frame, input ready);
    modport sink   (input valid, sample_left, sample_right, final_frame, output ready);
endinterface

interface lir_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          run_end;

    modport source (output valid, out_left, out_right, run_end, input ready);
    modport sink   (input valid, out_left, out_right, run_end, output ready);
endinterface

// ===== src/linear_interp_resampler_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linear_interp_resampler_unit
// Two-channel linear interpolation sample rate converter, Q5.16 step.
// ============================================================================
// Each accepted source frame runs through a small sequencer around one shared
// multiplier; the block drops src.ready until the frame is finished. A frame
// passes through bookkeeping states (transfer, first drain check, last loop
// check, update, flush) plus, for every destination frame that falls inside
// it, a loop check, two multiplier passes, one enqueue and one drain check,
// and one release step for every queued frame it releases. The final frame
// of a run adds an end-of-run queue release and a hold of the last frame,
// with one step per queued frame and per held repeat that it releases.
// Output transfers are decoupled by a stage register and an output register,
// so a waiting result only stalls the sequencer when both are full.
// Destination frame i sits at source position i*step; its value is
// a + round((b - a) * frac), half rounded up. A frame is released once a
// successor is known; the last frame of a run carries run_end. At most 32
// frames leave per source frame, the rest are dropped.
// ============================================================================
module linear_interp_resampler_unit
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int CHANNELS    = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lir_in_if.sink                      src,
    lir_out_if.source                   dst,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [FRAC_BITS+4:0]        cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = FRAC_BITS + 5;          // step register width
    localparam int PW  = FRAC_BITS + 6;          // positions and distances
    localparam int CW  = PW + 2;                 // compare width for 2x/3x
    localparam int DW  = SB + 1;                 // sample difference
    localparam int PRW = DW + FRAC_BITS + 1;     // product width

    localparam logic [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] STEP_LO = SW'(1) << (FRAC_BITS - 4);
    localparam logic [SW-1:0] STEP_HI = SW'(1) << (FRAC_BITS + 4);
    localparam logic [SW-1:0] STEP_RST = SW'(1) << FRAC_BITS;
    localparam logic signed [PRW-1:0] RND = PRW'(1) << (FRAC_BITS - 1);
    localparam logic [ECNT_W-1:0] EMIT_CAP = ECNT_W'(MAX_RESULTS);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [SW-1:0] step_reg;
    logic          mono_reg;

    // ------------------------------------------------------------------
    // Run state and sequencer
    // ------------------------------------------------------------------
    lir_state_t              state_reg, state_next;
    logic                    have_prev_reg;
    logic                    released_reg;
    logic                    fin_first_reg;
    logic                    final_reg;
    logic [PW-1:0]           next_pos_reg;
    logic [PW-1:0]           p_reg;
    logic [QCNT_W-1:0]       q_cnt_reg;
    logic [ECNT_W-1:0]       emit_cnt_reg;

    logic signed [SB-1:0]    cur_l_reg, cur_r_reg;
    logic signed [SB-1:0]    prev_l_reg, prev_r_reg;
    logic signed [SB-1:0]    tmp_l_reg;
    logic signed [PRW-1:0]   prod_reg;

    logic signed [SB-1:0]    q_l_reg [QUEUE_DEPTH];
    logic signed [SB-1:0]    q_r_reg [QUEUE_DEPTH];
    logic [PW-1:0]           q_d_reg [QUEUE_DEPTH];

    // Stage holds the newest result until it is known whether it ends the run
    logic                    stage_v_reg;
    logic signed [SB-1:0]    stage_l_reg, stage_r_reg;

    logic                    out_v_reg;
    logic                    out_end_reg;
    logic signed [SB-1:0]    out_l_reg, out_r_reg;

    // ------------------------------------------------------------------
    // Shared arithmetic
    // ------------------------------------------------------------------
    logic [SW-1:0]           step_eff;
    logic [PW-1:0]           step_pw;
    logic [CW-1:0]           head_d2, step3, step_c, hold_lhs, two_one;
    logic                    head_drain, head_fin_ok, hold_more;
    logic                    p_lt_one, q_full, q_empty;
    logic                    accept, out_free, cap_hit, emit_ok;
    logic signed [DW-1:0]    mul_a;
    logic signed [FRAC_BITS:0] mul_b;
    logic signed [PRW-1:0]   rnd_sum, rnd_sh;
    logic signed [SB-1:0]    interp_val, interp_prev;
    logic                    src_mono;

    // Control from the sequencer
    logic                    emit_req, emit_cur, pop_req, flush_done, advance;
    logic                    out_load;

    // Clamp the step to the range 1/16 .. 16
    always_comb
    begin
        if (step_reg < STEP_LO)
            step_eff = STEP_LO;
        else if (step_reg > STEP_HI)
            step_eff = STEP_HI;
        else
            step_eff = step_reg;
    end

    assign step_pw  = PW'(step_eff);
    assign step_c   = CW'(step_pw);
    assign step3    = step_c + (step_c << 1);
    assign head_d2  = CW'(q_d_reg[0]) << 1;
    assign hold_lhs = (CW'(p_reg) << 1) + step_c;
    assign two_one  = CW'(ONE) << 1;

    assign q_empty     = (q_cnt_reg == '0);
    assign q_full      = (q_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign p_lt_one    = (p_reg < ONE);
    assign head_drain  = !q_empty && (head_d2 >= step3);
    assign head_fin_ok = (head_d2 >= step_c) || (fin_first_reg && !released_reg);
    assign hold_more   = (hold_lhs <= two_one);

    assign accept   = src.valid && src.ready;
    assign out_free = !out_v_reg || dst.ready;
    assign cap_hit  = (emit_cnt_reg == EMIT_CAP);
    assign emit_ok  = cap_hit || !stage_v_reg || out_free;
    assign src_mono = mono_reg || (CHANNELS < 2);

    // One multiplier: left delta first, right delta on the next cycle
    assign mul_a = (state_reg == ST_MUL_L) ? (DW'(cur_l_reg) - DW'(prev_l_reg))
                                           : (DW'(cur_r_reg) - DW'(prev_r_reg));
    assign mul_b = $signed({1'b0, p_reg[FRAC_BITS-1:0]});

    assign interp_prev = (state_reg == ST_MUL_R) ? prev_l_reg : prev_r_reg;
    assign rnd_sum     = prod_reg + RND;
    assign rnd_sh      = rnd_sum >>> FRAC_BITS;
    assign interp_val  = interp_prev + rnd_sh[SB-1:0];

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        emit_req   = 1'b0;
        emit_cur   = 1'b0;
        pop_req    = 1'b0;
        flush_done = 1'b0;
        unique case (state_reg)
            ST_DRAIN:
            begin
                emit_req = head_drain;
                pop_req  = head_drain;
            end
            ST_LOOP:
            begin
                // A full queue releases its oldest frame early
                emit_req = p_lt_one && q_full;
                pop_req  = p_lt_one && q_full;
            end
            ST_FQ:
            begin
                emit_req = !q_empty && head_fin_ok;
                pop_req  = !q_empty && head_fin_ok;
            end
            ST_FHOLD:
            begin
                emit_req = hold_more;
                emit_cur = 1'b1;
            end
            ST_FLUSH:
            begin
                // A final frame that released nothing still yields the last frame
                emit_req   = final_reg && (emit_cnt_reg == '0);
                emit_cur   = 1'b1;
                flush_done = !emit_req && (!stage_v_reg || out_free);
            end
            default:
            begin
            end
        endcase
    end

    assign advance = !emit_req || emit_ok;

    // The staged frame moves to the output on a new emit or at the flush
    assign out_load = stage_v_reg && ((emit_req && emit_ok && !cap_hit) || flush_done);

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = have_prev_reg ? ST_DRAIN : ST_UPDATE;
            end
            ST_DRAIN:
            begin
                if (!head_drain)
                    state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (!p_lt_one)
                    state_next = ST_UPDATE;
                else if (!q_full)
                    state_next = ST_MUL_L;
            end
            ST_MUL_L:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_PUSH;
            ST_PUSH:   state_next = ST_DRAIN;
            ST_UPDATE: state_next = final_reg ? ST_FQ : ST_FLUSH;
            ST_FQ:
            begin
                if (q_empty)
                    state_next = ST_FHOLD;
                else if (!head_fin_ok)
                    state_next = ST_FLUSH;
            end
            ST_FHOLD:
            begin
                if (!hold_more)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (flush_done)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RST;
            mono_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            released_reg  <= 1'b0;
            fin_first_reg <= 1'b0;
            final_reg     <= 1'b0;
            next_pos_reg  <= '0;
            p_reg         <= '0;
            q_cnt_reg     <= '0;
            emit_cnt_reg  <= '0;
            stage_v_reg   <= 1'b0;
            out_v_reg     <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_STEP_Q16:    step_reg <= cfg_data;
                    REG_MONO_SOURCE: mono_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // Load the output from the stage, else drop it once its transfer
            // completes; only the flush of a final frame marks the run end
            if (out_load)
            begin
                out_v_reg   <= 1'b1;
                out_end_reg <= flush_done && final_reg;
            end
            else if (out_v_reg && dst.ready)
                out_v_reg <= 1'b0;

            if (accept)
            begin
                final_reg    <= src.final_frame;
                emit_cnt_reg <= '0;
                p_reg        <= next_pos_reg;
            end

            if (state_reg == ST_LOOP && !p_lt_one)
                next_pos_reg <= p_reg - ONE;

            if (state_reg == ST_PUSH)
            begin
                q_cnt_reg <= q_cnt_reg + QCNT_W'(1);
                p_reg     <= p_reg + step_pw;
            end

            if (pop_req && emit_ok)
            begin
                q_cnt_reg     <= q_cnt_reg - QCNT_W'(1);
                released_reg  <= 1'b1;
                fin_first_reg <= 1'b0;
            end

            if (state_reg == ST_UPDATE)
            begin
                have_prev_reg <= 1'b1;
                fin_first_reg <= 1'b1;
            end

            if (state_reg == ST_FQ && q_empty)
                p_reg <= next_pos_reg;

            if (state_reg == ST_FHOLD && hold_more && emit_ok)
                p_reg <= p_reg + step_pw;

            // Emit: the new result takes the stage
            if (emit_req && emit_ok && !cap_hit)
            begin
                emit_cnt_reg <= emit_cnt_reg + ECNT_W'(1);
                stage_v_reg  <= 1'b1;
            end

            if (flush_done)
            begin
                if (stage_v_reg)
                    stage_v_reg <= 1'b0;
                if (final_reg)
                begin
                    have_prev_reg <= 1'b0;
                    released_reg  <= 1'b0;
                    next_pos_reg  <= '0;
                    q_cnt_reg     <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample data
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_l_reg <= src.sample_left;
            cur_r_reg <= src_mono ? src.sample_left : src.sample_right;
            // Every pending frame moves one source frame further back
            for (int i = 0; i < QUEUE_DEPTH; i++)
                q_d_reg[i] <= q_d_reg[i] + ONE;
        end

        if (state_reg == ST_MUL_L || state_reg == ST_MUL_R)
            prod_reg <= mul_a * mul_b;

        if (state_reg == ST_MUL_R)
            tmp_l_reg <= interp_val;

        if (state_reg == ST_PUSH)
        begin
            q_l_reg[q_cnt_reg[QCNT_W-2:0]] <= tmp_l_reg;
            q_r_reg[q_cnt_reg[QCNT_W-2:0]] <= interp_val;
            q_d_reg[q_cnt_reg[QCNT_W-2:0]] <= (ONE << 1) - p_reg;
        end

        if (pop_req && emit_ok)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_l_reg[i] <= q_l_reg[i + 1];
                q_r_reg[i] <= q_r_reg[i + 1];
                q_d_reg[i] <= q_d_reg[i + 1];
            end
        end

        if (state_reg == ST_UPDATE)
        begin
            prev_l_reg <= cur_l_reg;
            prev_r_reg <= cur_r_reg;
        end

        if (emit_req && emit_ok && !cap_hit)
        begin
            stage_l_reg <= emit_cur ? cur_l_reg : q_l_reg[0];
            stage_r_reg <= emit_cur ? cur_r_reg : q_r_reg[0];
            if (stage_v_reg)
            begin
                out_l_reg <= stage_l_reg;
                out_r_reg <= stage_r_reg;
            end
        end

        if (flush_done && stage_v_reg)
        begin
            out_l_reg <= stage_l_reg;
            out_r_reg <= stage_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign src.ready     = (state_reg == ST_IDLE);
    assign dst.valid     = out_v_reg;
    assign dst.out_left  = out_l_reg;
    assign dst.out_right = out_r_reg;
    assign dst.run_end   = out_end_reg;

endmodule

// ===== src/lir_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lir_checker
// Port-level checks for the resampler, bound to the top level.
// ============================================================================
module lir_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    input  logic                          src_ready,
    input  logic                          dst_valid,
    input  logic                          dst_ready,
    input  logic signed [SAMPLE_BITS-1:0] dst_left,
    input  logic signed [SAMPLE_BITS-1:0] dst_right,
    input  logic                          dst_end
);

    // A stalled result holds its payload
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_left)
            && $stable(dst_right) && $stable(dst_end))
        else $error("stalled destination frame changed");

    // The sequencer is not ready again in the cycle after each transfer in
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !src_ready)
        else $error("source ready right after a transfer");

    // A new result only appears while a source frame is being worked on
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> !$past(src_ready))
        else $error("destination frame appeared while idle");

endmodule

bind linear_interp_resampler_unit lir_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src.valid),
    .src_ready (src.ready),
    .dst_valid (dst.valid),
    .dst_ready (dst.ready),
    .dst_left  (dst.out_left),
    .dst_right (dst.out_right),
    .dst_end   (dst.run_end)
);

// ===== tb/sv/linear_interp_resampler_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linear_interp_resampler_unit_tb
// Self-checking bench for the linear interpolation resampler. A directed
// table covers reset defaults, sample and step extremes, clamped steps, mono
// sources, one-frame runs and a step change in the middle of a run. Random
// runs of stereo frames follow, with random step and mono settings. Every
// destination frame is compared with an in-bench model of the converter or,
// for one-frame runs, a typed-in result. Both handshake sides idle at random.
// ============================================================================
module linear_interp_resampler_unit_tb;
    import lir_pkg::*;

    localparam int SW     = 24;
    localparam int FW     = 16;
    localparam int STEP_W = FW + 5;

    localparam longint UNIT = 64'sd1 << FW;   // 1.0 in Q16.16

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam int PENDING_DEPTH = 4;     // frames waiting for a successor
    localparam int WAIT_MAX      = 8;     // longest idle gap on either side
    localparam int SETTLE_CYCLES = 120;   // settling wait for a frame that releases nothing
    localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer at all
    localparam int RAND_ITEMS    = 150;

    typedef struct packed {
        logic signed [SW-1:0] out_left;
        logic signed [SW-1:0] out_right;
        logic                 run_end;
    } dest_frame_t;

    typedef enum logic [1:0] {
        ROW_CFG,     // settle, then write step and mono
        ROW_FRAME,   // send one frame, expect what the model computes
        ROW_FIXED    // send a one-frame run with its result typed in
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [STEP_W-1:0]    step;
        logic                 mono;
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 fin;
        logic signed [SW-1:0] want_left;
        logic signed [SW-1:0] want_right;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [STEP_W-1:0]    cfg_data;
    logic                 sink_ready = 1'b0;

    lir_in_if  #(.SAMPLE_BITS(SW)) src_if ();
    lir_out_if #(.SAMPLE_BITS(SW)) dst_if ();

    assign dst_if.ready = sink_ready;

    linear_interp_resampler_unit #(
        .SAMPLE_BITS (SW),
        .FRAC_BITS   (FW),
        .CHANNELS    (2)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_if),
        .dst       (dst_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    dest_frame_t pending_dest[$];   // destination frames still to arrive
    dest_frame_t burst[$];          // frames released by the last source frame
    stim_row_t   directed_rows[$];

    int  fail_count     = 0;
    int  frames_sent    = 0;
    int  frames_checked = 0;
    int  runs_done      = 0;
    int  settings_done  = 0;
    int  sink_hold      = 0;
    int  quiet_cycles   = 0;
    bit  steady         = 1'b0;    // when set, neither side idles

    // ------------------------------------------------------------------------
    // Converter model: register copies and run state
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0] step_reg;
    logic              mono_reg;
    bit                have_prev;
    longint            prev_left;
    longint            prev_right;
    longint            next_pos;     // next destination position, from prev
    int                wait_n;
    longint            wait_left  [PENDING_DEPTH];
    longint            wait_right [PENDING_DEPTH];
    longint            wait_dist  [PENDING_DEPTH];  // distance to known end
    bit                released;     // a frame of this run has left

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    function automatic void clear_run();
        have_prev  = 1'b0;
        prev_left  = 0;
        prev_right = 0;
        next_pos   = 0;
        wait_n     = 0;
        released   = 1'b0;
    endfunction

    // Drop anything past the per-frame cap of the block.
    function automatic void put_frame(longint l, longint r);
        dest_frame_t f;
        if (burst.size() >= MAX_RESULTS)
            return;
        f.out_left  = l[SW-1:0];
        f.out_right = r[SW-1:0];
        f.run_end   = 1'b0;
        burst.push_back(f);
    endfunction

    function automatic void release_oldest();
        put_frame(wait_left[0], wait_right[0]);
        released = 1'b1;
        for (int i = 1; i < wait_n; i++)
        begin
            wait_left[i-1]  = wait_left[i];
            wait_right[i-1] = wait_right[i];
            wait_dist[i-1]  = wait_dist[i];
        end
        wait_n--;
    endfunction

    // Release waiting frames that lie far enough behind the known end.
    function automatic void release_ripe(longint s);
        while (wait_n > 0 && 2 * wait_dist[0] >= 3 * s)
            release_oldest();
    endfunction

    // a + round((b - a) * frac), half up; the shift floors.
    function automatic longint lerp(longint a, longint b, longint frac);
        return a + (((b - a) * frac + (UNIT >>> 1)) >>> FW);
    endfunction

    // Work out every destination frame that one source frame releases.
    function automatic void resample_frame(logic signed [SW-1:0] l,
                                           logic signed [SW-1:0] r,
                                           logic fin);
        longint      s;
        longint      cl;
        longint      cr;
        longint      p;
        bit          all_ok;
        dest_frame_t last_f;
        burst.delete();
        s = step_reg;
        if (s < (UNIT >>> 4))
            s = UNIT >>> 4;
        if (s > (UNIT <<< 4))
            s = UNIT <<< 4;
        cl = l;
        cr = mono_reg ? cl : longint'(r);

        if (have_prev)
        begin
            p = next_pos;
            for (int i = 0; i < wait_n; i++)
                wait_dist[i] += UNIT;
            release_ripe(s);
            while (p < UNIT)
            begin
                if (wait_n >= PENDING_DEPTH)
                    release_oldest();
                wait_left[wait_n]  = lerp(prev_left, cl, p);
                wait_right[wait_n] = lerp(prev_right, cr, p);
                wait_dist[wait_n]  = 2 * UNIT - p;
                wait_n++;
                release_ripe(s);
                p += s;
            end
            next_pos = p - UNIT;
        end
        else
            next_pos = 0;
        prev_left  = cl;
        prev_right = cr;
        have_prev  = 1'b1;

        if (fin)
        begin
            all_ok = 1'b1;
            for (int i = 0; i < wait_n; i++)
            begin
                if (!(2 * wait_dist[i] >= s || (!released && i == 0)))
                begin
                    all_ok = 1'b0;
                    break;
                end
                put_frame(wait_left[i], wait_right[i]);
            end
            // Hold the last source frame until the run length is reached.
            if (all_ok)
            begin
                p = next_pos;
                while (2 * (UNIT - p) >= s)
                begin
                    put_frame(cl, cr);
                    p += s;
                end
            end
            if (burst.size() == 0)
                put_frame(cl, cr);
            last_f = burst.pop_back();
            last_f.run_end = 1'b1;
            burst.push_back(last_f);
            clear_run();
        end
    endfunction

    function automatic void queue_burst();
        foreach (burst[i])
            pending_dest.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic stim_row_t cfg_row(logic [STEP_W-1:0] step, logic mono);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.step = step;
        r.mono = mono;
        return r;
    endfunction

    function automatic stim_row_t frame_row(logic signed [SW-1:0] l,
                                            logic signed [SW-1:0] rt, logic fin);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_FRAME;
        r.left  = l;
        r.right = rt;
        r.fin   = fin;
        return r;
    endfunction

    // One-frame run that yields exactly one frame, marked as the run end.
    function automatic stim_row_t fixed_row(logic signed [SW-1:0] l,
                                            logic signed [SW-1:0] rt,
                                            logic signed [SW-1:0] wl,
                                            logic signed [SW-1:0] wr);
        stim_row_t r;
        r            = '0;
        r.kind       = ROW_FIXED;
        r.left       = l;
        r.right      = rt;
        r.fin        = 1'b1;
        r.want_left  = wl;
        r.want_right = wr;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------------
    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(0, 9))
            0:       return STEP_W'(UNIT >>> 4);
            1:       return STEP_W'(UNIT <<< 4);
            2:       return STEP_W'($urandom_range(0, 4095));
            3:       return STEP_W'($urandom_range(1048577, 2097151));
            4:       return STEP_W'(UNIT);
            5, 6:    return STEP_W'($urandom_range(4096, 65536));
            default: return STEP_W'($urandom_range(4096, 1048576));
        endcase
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SW'(int'($urandom_range(0, 64)) - 32);
            default: return SW'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one source frame after a random gap, hold it until the transfer,
    // then advance the model. Valid stays high when the next gap is zero.
    task automatic send_frame(input logic signed [SW-1:0] l,
                              input logic signed [SW-1:0] r,
                              input logic fin);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_if.valid        <= 1'b1;
        src_if.sample_left  <= l;
        src_if.sample_right <= r;
        src_if.final_frame  <= fin;
        do
            @(posedge clk);
        while (!src_if.ready);
        frames_sent++;
        resample_frame(l, r, fin);
    endtask

    // Hold off the sender until every expected frame is back, then give the
    // block time to finish a frame that releases nothing.
    task automatic settle();
        src_if.valid <= 1'b0;
        while (pending_dest.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; cfg_write stays high.
    task automatic apply_setting(input logic [STEP_W-1:0] step, input logic mono);
        cfg_write <= 1'b1;
        cfg_index <= REG_STEP_Q16;
        cfg_data  <= step;
        @(posedge clk);
        step_reg = step;
        cfg_index <= REG_MONO_SOURCE;
        cfg_data  <= STEP_W'(mono);
        @(posedge clk);
        mono_reg = mono;
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    // ------------------------------------------------------------------------
    // Destination side: random stalls and the field-by-field check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : dest_check
        dest_frame_t want;
        if (!rst_n)
            sink_ready <= 1'b0;
        else
        begin
            if (dst_if.valid && dst_if.ready)
            begin
                frames_checked++;
                if (pending_dest.size() == 0)
                begin
                    $error("unexpected destination frame: out_left=%0d out_right=%0d run_end=%0d",
                           dst_if.out_left, dst_if.out_right, dst_if.run_end);
                    fail_count++;
                end
                else
                begin
                    want = pending_dest.pop_front();
                    if (dst_if.out_left !== want.out_left)
                    begin
                        $error("out_left: expected %0d, got %0d",
                               want.out_left, dst_if.out_left);
                        fail_count++;
                    end
                    if (dst_if.out_right !== want.out_right)
                    begin
                        $error("out_right: expected %0d, got %0d",
                               want.out_right, dst_if.out_right);
                        fail_count++;
                    end
                    if (dst_if.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d",
                               want.run_end, dst_if.run_end);
                        fail_count++;
                    end
                end
                sink_hold = draw_wait();
            end
            else if (sink_hold > 0)
                sink_hold--;
            sink_ready <= (sink_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when neither side moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d frames outstanding",
                         quiet_cycles, pending_dest.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int          run_len;
        int          rand_frames;
        logic        fin;
        dest_frame_t want;

        src_if.valid        = 1'b0;
        src_if.sample_left  = '0;
        src_if.sample_right = '0;
        src_if.final_frame  = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = REG_STEP_Q16;
        cfg_data            = '0;

        step_reg = STEP_W'(UNIT);
        mono_reg = 1'b0;
        clear_run();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults (step 1, stereo): a single frame comes back as is.
        directed_rows.push_back(fixed_row(S_MAX, S_MIN, S_MAX, S_MIN));
        // Full-scale swings at step 1, then at step 1/2 where the half-way
        // fraction exercises rounding of the largest delta.
        directed_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
        directed_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        directed_rows.push_back(frame_row(24'sd0, -24'sd1, 1'b1));
        directed_rows.push_back(cfg_row(21'h08000, 1'b0));
        directed_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
        directed_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        directed_rows.push_back(frame_row(-24'sd1, 24'sd1, 1'b1));
        // Lowest step: sixteen destination frames per source frame.
        directed_rows.push_back(cfg_row(21'h01000, 1'b0));
        directed_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
        directed_rows.push_back(frame_row(S_MIN, S_MAX, 1'b1));
        // Highest step: a one-frame run still yields one frame.
        directed_rows.push_back(cfg_row(21'h100000, 1'b0));
        directed_rows.push_back(fixed_row(-24'sd5, 24'sd7, -24'sd5, 24'sd7));
        directed_rows.push_back(frame_row(24'sd100, -24'sd200, 1'b0));
        directed_rows.push_back(frame_row(24'sd300, 24'sd400, 1'b0));
        directed_rows.push_back(frame_row(-24'sd500, 24'sd600, 1'b1));
        // Step below range clamps to 1/16; mono source repeats the left input.
        directed_rows.push_back(cfg_row(21'h000000, 1'b1));
        directed_rows.push_back(frame_row(24'sd1234, -24'sd999, 1'b1));
        // Step above range clamps to 16; mono copies left into both outputs.
        directed_rows.push_back(cfg_row(21'h1FFFFF, 1'b1));
        directed_rows.push_back(fixed_row(S_MIN, 24'sd5, S_MIN, S_MIN));
        // Step change in the middle of a run.
        directed_rows.push_back(cfg_row(21'h10000, 1'b0));
        directed_rows.push_back(frame_row(24'sd10, 24'sd20, 1'b0));
        directed_rows.push_back(cfg_row(21'h01000, 1'b0));
        directed_rows.push_back(frame_row(24'sd30, 24'sd40, 1'b0));
        directed_rows.push_back(cfg_row(21'h30000, 1'b0));
        directed_rows.push_back(frame_row(24'sd50, 24'sd60, 1'b0));
        directed_rows.push_back(frame_row(24'sd70, 24'sd80, 1'b1));
        // Step 1.5, stereo, a short run.
        directed_rows.push_back(cfg_row(21'h18000, 1'b0));
        directed_rows.push_back(frame_row(-24'sd4000, 24'sd4000, 1'b0));
        directed_rows.push_back(frame_row(24'sd8000, -24'sd8000, 1'b0));
        directed_rows.push_back(frame_row(S_MAX, S_MIN, 1'b1));

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_CFG:
                begin
                    settle();
                    apply_setting(directed_rows[i].step, directed_rows[i].mono);
                end
                ROW_FRAME:
                begin
                    send_frame(directed_rows[i].left, directed_rows[i].right,
                               directed_rows[i].fin);
                    queue_burst();
                    if (directed_rows[i].fin)
                        runs_done++;
                end
                default:
                begin
                    send_frame(directed_rows[i].left, directed_rows[i].right, 1'b1);
                    want.out_left  = directed_rows[i].want_left;
                    want.out_right = directed_rows[i].want_right;
                    want.run_end   = 1'b1;
                    pending_dest.push_back(want);
                    runs_done++;
                end
            endcase
        end

        // Random runs: mostly complete runs with random content, now and then
        // a setting change in the middle of a run.
        rand_frames = 0;
        while (rand_frames < RAND_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                apply_setting(random_step(), 1'($urandom_range(0, 1)));
            end
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 16)
                                                  : $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++)
            begin
                fin = (k == run_len - 1);
                if (!fin && $urandom_range(0, 9) == 0)
                begin
                    settle();
                    apply_setting(random_step(), 1'($urandom_range(0, 1)));
                end
                send_frame(random_sample(), random_sample(), fin);
                queue_burst();
                rand_frames++;
            end
            runs_done++;
        end

        // Drain: every run ended with a final frame, so all results flush.
        steady = 1'b0;
        src_if.valid <= 1'b0;
        while (pending_dest.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d source frames in %0d runs; checked %0d destination frames.",
                 frames_sent, runs_done, frames_checked);
        $display("Applied %0d step/mono settings, including clamped and extreme steps.",
                 settings_done);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
